### rtl/core/bdeq_pkg.sv
// bdeq_pkg: shared types and constants for the bounded double-ended queue
// used by bdeq_cell, bounded_double_ended_queue and bdeq_checker
package bdeq_pkg;

   localparam int DEPTH_DEF = 64;
   localparam int DATA_W    = 32;
   localparam int CAP_W     = 7;
   localparam int FUNC_W    = 3;

   localparam logic [CAP_W-1:0]  CAP_RESET   = CAP_W'(64);
   localparam logic [DATA_W-1:0] EMPTY_VALUE = '1;

   // operation codes; any other code is a plain query
   localparam logic [FUNC_W-1:0] FUNC_PUSH_FRONT = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_PUSH_REAR  = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_POP_FRONT  = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_POP_REAR   = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_QUERY      = 3'd4;

   typedef struct packed {
      logic [FUNC_W-1:0]        func;
      logic signed [DATA_W-1:0] value;
   } bdeq_req_type;

   typedef struct packed {
      logic                     ok;
      logic signed [DATA_W-1:0] front_value;
      logic signed [DATA_W-1:0] rear_value;
      logic                     is_empty;
      logic                     is_full;
   } bdeq_rsp_type;

   // command broadcast to every cell of the row
   typedef struct packed {
      logic push_front;
      logic push_rear;
      logic pop_front;
      logic pop_rear;
      logic clear;
   } bdeq_cmd_type;

endpackage

### rtl/core/bdeq_cell.sv
// bdeq_cell: one slot of the deque row, holding the front-ordered copy,
// the rear-ordered copy and an occupied bit; depends on bdeq_pkg
module bdeq_cell (
   input  logic                        clock,
   input  logic                        reset,
   input  bdeq_pkg::bdeq_cmd_type      cmd,
   input  logic [bdeq_pkg::DATA_W-1:0] push_value,
   input  logic [bdeq_pkg::DATA_W-1:0] left_a,
   input  logic [bdeq_pkg::DATA_W-1:0] left_b,
   input  logic                        left_occ,
   input  logic [bdeq_pkg::DATA_W-1:0] right_a,
   input  logic [bdeq_pkg::DATA_W-1:0] right_b,
   input  logic                        right_occ,
   output logic [bdeq_pkg::DATA_W-1:0] a_q,
   output logic [bdeq_pkg::DATA_W-1:0] b_q,
   output logic                        occ_q
);
   import bdeq_pkg::*;

   logic [DATA_W-1:0] a_ff, a_in;
   logic [DATA_W-1:0] b_ff, b_in;
   logic              occ_ff, occ_in;
   logic              free_slot;

   // first unoccupied slot: where the far end of each copy grows
   assign free_slot = left_occ && !occ_ff;

   always_comb begin
      a_in   = a_ff;
      b_in   = b_ff;
      occ_in = occ_ff;
      if (cmd.clear) begin
         occ_in = 1'b0;
      end else if (cmd.push_front) begin
         a_in   = left_a;
         occ_in = left_occ;
         if (free_slot) begin
            b_in = push_value;
         end
      end else if (cmd.push_rear) begin
         b_in   = left_b;
         occ_in = left_occ;
         if (free_slot) begin
            a_in = push_value;
         end
      end else if (cmd.pop_front) begin
         a_in   = right_a;
         occ_in = right_occ;
      end else if (cmd.pop_rear) begin
         b_in   = right_b;
         occ_in = right_occ;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
   end

   assign a_q   = a_ff;
   assign b_q   = b_ff;
   assign occ_q = occ_ff;

endmodule

### rtl/core/bounded_double_ended_queue.sv
// bounded_double_ended_queue: top level, a row of bdeq_cell slots with
// count, capacity and result buffering; depends on bdeq_pkg and bdeq_cell
//
// Bounded deque of signed 32-bit values. Each request item carries one
// operation (push front, push rear, pop front, pop rear, or query; unknown
// codes act as a query) and yields exactly one response item with ok, the
// front and rear values (-1 when empty) and the empty and full flags after
// the operation. A refused push (full) or pop (empty) changes nothing.
// Storage is a row of DEPTH cells that shift toward or away from the head;
// two copies are kept, one ordered from the front and one from the rear, so
// both ends are always in cell 0. One item is taken per clock while req_stall
// is low: the response leaves from an output register backed by one skid
// entry, so req_stall only rises once two responses are waiting. Writing the
// capacity register (csr_wdata, always ready) empties the deque; capacities
// above DEPTH act as DEPTH, zero refuses every push.
module bounded_double_ended_queue #(
   parameter int DEPTH = bdeq_pkg::DEPTH_DEF
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  bdeq_pkg::bdeq_req_type     req_data,
   output logic                       rsp_valid,
   input  logic                       rsp_stall,
   output bdeq_pkg::bdeq_rsp_type     rsp_data,
   input  logic                       csr_valid,
   output logic                       csr_ready,
   input  logic [bdeq_pkg::CAP_W-1:0] csr_wdata
);
   import bdeq_pkg::*;

   localparam int CW = $clog2(DEPTH + 1);
   localparam int LW = (CW > CAP_W) ? CW : CAP_W;

   logic [CW-1:0]     count_ff, count_in;
   logic [CAP_W-1:0]  cap_ff;
   logic              rsp_valid_ff, skid_valid_ff;
   bdeq_rsp_type      rsp_ff, skid_ff;
   bdeq_rsp_type      result;
   bdeq_cmd_type      cmd;
   logic              accept, csr_write, rsp_take;
   logic              empty_now, full_now, empty_in;
   logic [DATA_W-1:0] front_in, rear_in;

   logic [DATA_W-1:0] a_row [DEPTH+1];
   logic [DATA_W-1:0] b_row [DEPTH+1];
   logic              occ_row [DEPTH+1];

   assign accept    = req_valid && !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid;
   assign rsp_take  = rsp_valid_ff && !rsp_stall;

   assign empty_now = (count_ff == '0);
   assign full_now  = (LW'(count_ff) >= LW'(cap_ff)) || (count_ff == CW'(DEPTH));

   // decode the operation into a row command
   always_comb begin
      cmd       = '0;
      cmd.clear = csr_write;
      result    = '0;
      result.ok = 1'b1;
      count_in  = count_ff;
      case (req_data.func)
         FUNC_PUSH_FRONT: begin
            result.ok      = !full_now;
            cmd.push_front = accept && !full_now;
         end
         FUNC_PUSH_REAR: begin
            result.ok     = !full_now;
            cmd.push_rear = accept && !full_now;
         end
         FUNC_POP_FRONT: begin
            result.ok     = !empty_now;
            cmd.pop_front = accept && !empty_now;
         end
         FUNC_POP_REAR: begin
            result.ok    = !empty_now;
            cmd.pop_rear = accept && !empty_now;
         end
         default: begin
            result.ok = 1'b1;
         end
      endcase
      if (cmd.push_front || cmd.push_rear) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.pop_front || cmd.pop_rear) begin
         count_in = count_ff - CW'(1);
      end

      // head cell of each copy after the operation
      if (cmd.push_front || (cmd.push_rear && empty_now)) begin
         front_in = req_data.value;
      end else if (cmd.pop_front) begin
         front_in = a_row[1];
      end else begin
         front_in = a_row[0];
      end
      if (cmd.push_rear || (cmd.push_front && empty_now)) begin
         rear_in = req_data.value;
      end else if (cmd.pop_rear) begin
         rear_in = b_row[1];
      end else begin
         rear_in = b_row[0];
      end

      empty_in           = (count_in == '0);
      result.is_empty    = empty_in;
      result.is_full     = (LW'(count_in) >= LW'(cap_ff)) || (count_in == CW'(DEPTH));
      result.front_value = empty_in ? EMPTY_VALUE : front_in;
      result.rear_value  = empty_in ? EMPTY_VALUE : rear_in;
   end

   // row boundary past the last cell
   assign a_row[DEPTH]   = '0;
   assign b_row[DEPTH]   = '0;
   assign occ_row[DEPTH] = 1'b0;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      if (i == 0) begin : g_head
         bdeq_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cmd        (cmd),
            .push_value (req_data.value),
            .left_a     (req_data.value),
            .left_b     (req_data.value),
            .left_occ   (1'b1),
            .right_a    (a_row[i+1]),
            .right_b    (b_row[i+1]),
            .right_occ  (occ_row[i+1]),
            .a_q        (a_row[i]),
            .b_q        (b_row[i]),
            .occ_q      (occ_row[i])
         );
      end else begin : g_body
         bdeq_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .cmd        (cmd),
            .push_value (req_data.value),
            .left_a     (a_row[i-1]),
            .left_b     (b_row[i-1]),
            .left_occ   (occ_row[i-1]),
            .right_a    (a_row[i+1]),
            .right_b    (b_row[i+1]),
            .right_occ  (occ_row[i+1]),
            .a_q        (a_row[i]),
            .b_q        (b_row[i]),
            .occ_q      (occ_row[i])
         );
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         cap_ff   <= CAP_RESET;
      end else if (csr_write) begin
         count_ff <= '0;
         cap_ff   <= csr_wdata;
      end else begin
         count_ff <= count_in;
      end
   end

   // output register with one skid entry behind it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || rsp_take) begin
         if (skid_valid_ff) begin
            rsp_valid_ff  <= 1'b1;
            skid_valid_ff <= 1'b0;
         end else begin
            rsp_valid_ff <= accept;
         end
      end else if (accept) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || rsp_take) begin
         if (skid_valid_ff) begin
            rsp_ff <= skid_ff;
         end else if (accept) begin
            rsp_ff <= result;
         end
      end else if (accept) begin
         skid_ff <= result;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

### rtl/core/bdeq_checker.sv
// bdeq_props: port-level checks on bounded_double_ended_queue, bound
// to the top level below; depends on bdeq_pkg
module bdeq_props (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input bdeq_pkg::bdeq_rsp_type rsp_data
);
   import bdeq_pkg::*;

   // a held response keeps its item
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response changed while stalled");

   // an empty deque reports -1 at both ends
   a_empty_values: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.is_empty |->
         rsp_data.front_value == EMPTY_VALUE && rsp_data.rear_value == EMPTY_VALUE)
      else $error("empty response with live end values");

   // a response appears only after an accepted request item
   a_rsp_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_valid && !req_stall))
      else $error("response without a request");

   // no response right after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response valid after reset");

endmodule

bind bounded_double_ended_queue bdeq_props u_bdeq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);
